/* rtl/cscan_pkg.sv */
// shared types for the c-scan disk scheduler
// no dependencies
package cscan_pkg;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEEK,
    ST_UP,
    ST_TOP,
    ST_ZERO,
    ST_LOW
  } back_state_t;

  // status of the closed batch held between front and back
  typedef struct packed {
    logic closed;
    logic overflow;
  } batch_stat_t;

  localparam int SEEK_W   = 18;
  localparam int SERVE_W  = 16;
  localparam int CFG_IDX_DISK  = 0;
  localparam int CFG_IDX_START = 1;

endpackage

/* rtl/cscan_front.sv */
// front end: accepts requests and keeps them in a sorted register line
// depends on cscan_pkg
module cscan_front #(
  parameter int MAX_REQUESTS = 32,
  parameter int TRACK_BITS   = 16,
  parameter int CW           = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [TRACK_BITS-1:0] track,
  input  logic                  last,
  input  logic                  take,
  output cscan_pkg::batch_stat_t stat,
  output logic [CW-1:0]         count,
  output logic [TRACK_BITS-1:0] line [MAX_REQUESTS]
);
  import cscan_pkg::*;

  logic [MAX_REQUESTS-1:0] gt;
  logic                    room;

  assign room = (count < CW'(MAX_REQUESTS));

  // entries above the new request move up one place
  always_comb begin
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      gt[i] = (CW'(i) < count) && (line[i] > track);
    end
  end

  // insertion into the sorted line
  always_ff @(posedge clk) begin
    if (accept && room) begin
      for (int i = 0; i < MAX_REQUESTS; i++) begin
        if (gt[i]) begin
          if (i == 0) line[i] <= track;
          else if (!gt[i-1]) line[i] <= track;
          else line[i] <= line[i-1];
        end else if (CW'(i) == count) begin
          // first free place takes the shifted top entry or the new request
          if (i == 0) line[i] <= track;
          else if (gt[i-1]) line[i] <= line[i-1];
          else line[i] <= track;
        end
      end
    end
  end

  // request count and batch status
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      stat  <= '0;
    end else if (take) begin
      count <= '0;
      stat  <= '0;
    end else if (accept) begin
      if (room) count <= count + CW'(1);
      else stat.overflow <= 1'b1;
      if (last) stat.closed <= 1'b1;
    end
  end

endmodule

/* rtl/cscan_back.sv */
// back end: walks a sorted batch and emits the c-scan service order
// depends on cscan_pkg
module cscan_back #(
  parameter int MAX_REQUESTS = 32,
  parameter int TRACK_BITS   = 16,
  parameter int CW           = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cscan_pkg::batch_stat_t stat,
  input  logic [CW-1:0]         count_in,
  input  logic [TRACK_BITS-1:0] line_in [MAX_REQUESTS],
  input  logic [TRACK_BITS-1:0] top,
  input  logic [TRACK_BITS-1:0] head,
  output logic                  take,
  output logic                  result_valid,
  output logic [cscan_pkg::SERVE_W-1:0] service_track,
  output logic [cscan_pkg::SEEK_W-1:0]  total_seek,
  output logic                  overflow_seen,
  output logic                  sequence_end
);
  import cscan_pkg::*;

  localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int SW = TRACK_BITS + 2;

  back_state_t             state, state_next;
  logic [TRACK_BITS-1:0]   store [MAX_REQUESTS];
  logic [CW-1:0]           count;
  logic [CW-1:0]           idx;
  logic                    ovf;
  logic [TRACK_BITS-1:0]   max_low;
  logic [CW-1:0]           last_low;
  logic                    has_low;
  logic [SW-1:0]           seek_sum;
  logic [SEEK_W-1:0]       seek;
  logic [TRACK_BITS-1:0]   cur;
  logic                    in_range;
  logic                    emit;
  logic [TRACK_BITS-1:0]   emit_val;
  logic                    emit_end;

  // current entry, clamped to the top track
  always_comb begin
    cur = store[idx[IW-1:0]];
    if (cur > top) cur = top;
  end
  assign in_range = (idx < count);
  assign take = (state == ST_IDLE) && stat.closed;

  // total seek, saturated
  always_comb begin
    seek_sum = (top >= head) ? SW'(top - head) : SW'(head - top);
    seek_sum = seek_sum + SW'(top) + SW'(max_low);
    if (seek_sum > SW'(2**SEEK_W - 1)) seek = '1;
    else seek = SEEK_W'(seek_sum);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (stat.closed) state_next = ST_SCAN;
      ST_SCAN: if (!in_range) state_next = ST_SEEK;
      ST_SEEK: state_next = ST_UP;
      ST_UP:   if (!in_range) state_next = ST_TOP;
      ST_TOP:  state_next = ST_ZERO;
      ST_ZERO: state_next = has_low ? ST_LOW : ST_IDLE;
      ST_LOW:  if (idx == last_low) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // result selection
  always_comb begin
    emit     = 1'b0;
    emit_val = cur;
    emit_end = 1'b0;
    case (state)
      ST_UP:   emit = in_range && (cur > head);
      ST_TOP: begin
        emit     = 1'b1;
        emit_val = top;
      end
      ST_ZERO: begin
        emit     = 1'b1;
        emit_val = '0;
        emit_end = !has_low;
      end
      ST_LOW: begin
        emit     = 1'b1;
        emit_end = (idx == last_low);
      end
      default: emit = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= emit;
    end
  end

  // batch copy, scan and walk
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        idx     <= '0;
        has_low <= 1'b0;
        max_low <= '0;
        if (take) begin
          store <= line_in;
          count <= count_in;
          ovf   <= stat.overflow;
        end
      end
      ST_SCAN: begin
        if (in_range) begin
          if (cur < head) begin
            max_low  <= cur;
            last_low <= idx;
            has_low  <= 1'b1;
          end
          idx <= idx + CW'(1);
        end
      end
      ST_SEEK: begin
        total_seek <= seek;
        idx        <= '0;
      end
      ST_UP:   if (in_range) idx <= idx + CW'(1);
      ST_ZERO: idx <= '0;
      ST_LOW:  idx <= idx + CW'(1);
      default: idx <= idx;
    endcase
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      service_track <= SERVE_W'(emit_val);
      overflow_seen <= ovf;
      sequence_end  <= emit_end;
    end
  end

endmodule

/* rtl/cscan_disk_scheduler_unit.sv */
// c-scan disk scheduler, top level with configuration registers
// depends on cscan_pkg, cscan_front, cscan_back
// a request enters while busy is low; busy holds while a closed batch waits for the back
// with the back idle, a batch is copied and scanned for requests below the head, then
// served upward from the head, followed by the top track, track zero and the low requests
// one result per cycle at most, each strobed for one cycle, no stall from the receiver
// synchronous active-high reset clears the batch and sequencer, resets the configuration
module cscan_disk_scheduler_unit #(
  parameter int MAX_REQUESTS = 32,
  parameter int TRACK_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] request_track,
  input  logic        batch_last,
  input  logic        cfg_wr,
  input  logic        cfg_addr,
  input  logic [16:0] cfg_data,
  output logic        result_valid,
  output logic [cscan_pkg::SERVE_W-1:0] service_track,
  output logic [cscan_pkg::SEEK_W-1:0]  total_seek,
  output logic        overflow_seen,
  output logic        sequence_end
);
  import cscan_pkg::*;

  localparam int CW = $clog2(MAX_REQUESTS + 1);

  logic [16:0]           disk_tracks;
  logic [15:0]           start_track;
  logic [23:0]           req_ext;
  logic [23:0]           start_ext;
  logic [16:0]           dt_m1;
  logic [24:0]           top_ext;
  logic [24:0]           mask_ext;
  logic [24:0]           top_sat;
  logic [TRACK_BITS-1:0] top;
  logic [TRACK_BITS-1:0] head;
  logic                  accept;
  logic                  take;
  batch_stat_t           stat;
  logic [CW-1:0]         count;
  logic [TRACK_BITS-1:0] line [MAX_REQUESTS];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_tracks <= 17'd200;
      start_track <= '0;
    end else if (cfg_wr) begin
      if (cfg_addr == 1'(CFG_IDX_DISK)) disk_tracks <= cfg_data;
      else start_track <= cfg_data[15:0];
    end
  end

  // top track and head at track width
  always_comb begin
    dt_m1     = (disk_tracks == '0) ? '0 : disk_tracks - 17'd1;
    top_ext   = {8'b0, dt_m1};
    mask_ext  = (25'(1) << TRACK_BITS) - 25'(1);
    top_sat   = (top_ext > mask_ext) ? mask_ext : top_ext;
    top       = top_sat[TRACK_BITS-1:0];
    start_ext = {8'b0, start_track};
    head      = start_ext[TRACK_BITS-1:0];
    req_ext   = {8'b0, request_track};
  end

  assign busy   = stat.closed;
  assign accept = start && !busy;

  cscan_front #(
    .MAX_REQUESTS(MAX_REQUESTS),
    .TRACK_BITS(TRACK_BITS),
    .CW(CW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .track(req_ext[TRACK_BITS-1:0]),
    .last(batch_last),
    .take(take),
    .stat(stat),
    .count(count),
    .line(line)
  );

  cscan_back #(
    .MAX_REQUESTS(MAX_REQUESTS),
    .TRACK_BITS(TRACK_BITS),
    .CW(CW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .stat(stat),
    .count_in(count),
    .line_in(line),
    .top(top),
    .head(head),
    .take(take),
    .result_valid(result_valid),
    .service_track(service_track),
    .total_seek(total_seek),
    .overflow_seen(overflow_seen),
    .sequence_end(sequence_end)
  );

endmodule
